// ===== rtl/tsk_pkg.sv =====
`timescale 1ns / 1ps
package tsk_pkg;

   localparam int DEG_W = 6;

   localparam logic [1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [1:0] OP_SORT     = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_POP,
      ST_WALK,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DEG_HOLD,
      DEG_LOAD,
      DEG_ADD,
      DEG_DEC
   } deg_mode_type;

   typedef struct packed {
      logic [DEG_W-1:0] value;
      logic             write;
      logic             is_zero;
      logic             to_zero;
   } deg_result_type;

endpackage

// ===== rtl/tsk_degree_unit.sv =====
`timescale 1ns / 1ps
module tsk_degree_unit
   import tsk_pkg::*;
(
   input  deg_mode_type     mode,
   input  logic [DEG_W-1:0] degree,
   input  logic             edge_bit,
   output deg_result_type   result
);

   always_comb begin
      result.value   = degree;
      result.write   = 1'b0;
      result.is_zero = (degree == '0);
      result.to_zero = 1'b0;
      case (mode)
         DEG_HOLD: begin
            result.write = 1'b0;
         end
         DEG_LOAD: begin
            result.value = {{(DEG_W-1){1'b0}}, edge_bit};
            result.write = 1'b1;
         end
         DEG_ADD: begin
            result.value = degree + {{(DEG_W-1){1'b0}}, edge_bit};
            result.write = 1'b1;
         end
         DEG_DEC: begin
            result.value   = degree - {{(DEG_W-1){1'b0}}, 1'b1};
            result.write   = edge_bit && (degree != '0);
            result.to_zero = edge_bit && (degree == {{(DEG_W-1){1'b0}}, 1'b1});
         end
         default: begin
            result.write = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/topological_sort_kahn.sv =====
`timescale 1ns / 1ps
// Kahn topological sort over an adjacency bit matrix. An add-edge or clear item
// leaves busy low, so such items can be issued every cycle. A sort item raises
// busy while one shared in-degree update unit walks the matrix bit by bit: it
// counts in-degrees, queues the sources, walks the row of each visited vertex,
// closes the walk, judges the run and then emits the order, for n vertices in use.
// csr_ready stays low while busy. Results come one per cycle on rsp_valid, the
// last marked by rsp_last_of_run; a cyclic graph gives one result with
// rsp_cycle_detected set. The receiver cannot stall: every result must be taken
// in the cycle it is shown.
module topological_sort_kahn
   import tsk_pkg::*;
#(
   parameter int MAX_VERTICES = 32
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [4:0] req_src_vertex,
   input  logic [4:0] req_dst_vertex,
   output logic       rsp_valid,
   output logic [4:0] rsp_vertex,
   output logic       rsp_last_of_run,
   output logic       rsp_cycle_detected,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_data
);

   localparam int VCAP = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
   localparam int IW   = $clog2(VCAP);
   localparam int CW   = $clog2(VCAP + 1);
   localparam logic [5:0] VCAP6 = 6'(VCAP);

   state_type state_ff, state_in;

   logic [VCAP-1:0]  adj_ff   [VCAP];
   logic [DEG_W-1:0] deg_ff   [VCAP];
   logic [IW-1:0]    queue_ff [VCAP];
   logic [IW-1:0]    order_ff [VCAP];

   logic [5:0]    vertex_count_ff;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] head_ff, head_in;
   logic [CW-1:0] tail_ff, tail_in;
   logic [CW-1:0] visited_ff, visited_in;
   logic [IW-1:0] cur_ff, cur_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_vertex_ff, rsp_vertex_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_cycle_ff, rsp_cycle_in;

   logic [5:0]    n_full;
   logic [CW-1:0] n;
   logic [CW-1:0] n_m1;
   logic          accept;
   logic          edge_ok;
   logic          adj_set;
   logic          adj_clear;
   logic          q_we;
   logic          ord_we;
   logic [IW-1:0] j_idx;
   logic [IW-1:0] row_idx;
   logic          edge_bit;

   deg_mode_type   deg_mode;
   deg_result_type deg_res;

   assign n_full = (vertex_count_ff == 6'd0) ? 6'd1 :
                   (vertex_count_ff > VCAP6) ? VCAP6 : vertex_count_ff;
   assign n      = n_full[CW-1:0];
   assign n_m1   = n - {{(CW-1){1'b0}}, 1'b1};
   assign accept = start && !busy;
   assign edge_ok = ({1'b0, req_src_vertex} < n_full) && ({1'b0, req_dst_vertex} < n_full);
   assign j_idx   = j_ff[IW-1:0];
   assign row_idx = (state_ff == ST_WALK) ? cur_ff : i_ff[IW-1:0];
   assign edge_bit = adj_ff[row_idx][j_idx];

   tsk_degree_unit u_deg (
      .mode     (deg_mode),
      .degree   (deg_ff[j_idx]),
      .edge_bit (edge_bit),
      .result   (deg_res)
   );

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      visited_in    = visited_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_cycle_in  = rsp_cycle_ff;
      adj_set       = 1'b0;
      adj_clear     = 1'b0;
      q_we          = 1'b0;
      ord_we        = 1'b0;
      deg_mode      = DEG_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_ADD_EDGE: adj_set = edge_ok;
                  OP_CLEAR:    adj_clear = 1'b1;
                  OP_SORT: begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_COUNT;
                  end
                  default: ;
               endcase
            end
         end
         ST_COUNT: begin
            deg_mode = (i_ff == '0) ? DEG_LOAD : DEG_ADD;
            j_in     = j_ff + 1'b1;
            if (j_ff == n_m1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
               if (i_ff == n_m1) begin
                  tail_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (deg_res.is_zero) begin
               q_we    = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            j_in = j_ff + 1'b1;
            if (j_ff == n_m1) begin
               head_in    = '0;
               visited_in = '0;
               state_in   = ST_POP;
            end
         end
         ST_POP: begin
            if ((head_ff < tail_ff) && (visited_ff < n)) begin
               cur_in     = queue_ff[head_ff[IW-1:0]];
               ord_we     = 1'b1;
               head_in    = head_ff + 1'b1;
               visited_in = visited_ff + 1'b1;
               j_in       = '0;
               state_in   = ST_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            deg_mode = DEG_DEC;
            if (deg_res.to_zero) begin
               q_we    = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            j_in = j_ff + 1'b1;
            if (j_ff == n_m1) begin
               state_in = ST_POP;
            end
         end
         ST_FINISH: begin
            if (visited_ff != n) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = '0;
               rsp_last_in   = 1'b1;
               rsp_cycle_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               j_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = 5'(order_ff[j_idx]);
            rsp_last_in   = (j_ff == n_m1);
            rsp_cycle_in  = 1'b0;
            j_in          = j_ff + 1'b1;
            if (j_ff == n_m1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= 6'd32;
         head_ff         <= '0;
         tail_ff         <= '0;
         visited_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            vertex_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      cur_ff        <= cur_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_cycle_ff  <= rsp_cycle_in;
   end

   // adjacency rows are emptied on reset or a clear item
   always_ff @(posedge clock) begin
      if (reset || adj_clear) begin
         for (int r = 0; r < VCAP; r++) begin
            adj_ff[r] <= '0;
         end
      end else if (adj_set) begin
         adj_ff[req_src_vertex[IW-1:0]][req_dst_vertex[IW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (deg_res.write) begin
         deg_ff[j_idx] <= deg_res.value;
      end
      if (q_we) begin
         queue_ff[tail_ff[IW-1:0]] <= j_idx;
      end
      if (ord_we) begin
         order_ff[visited_ff[IW-1:0]] <= queue_ff[head_ff[IW-1:0]];
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = !busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_vertex         = rsp_vertex_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_cycle_detected = rsp_cycle_ff;

endmodule

// ===== rtl/tsk_checker.sv =====
`timescale 1ns / 1ps
module tsk_checker
   import tsk_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic [4:0] rsp_vertex,
   input logic       rsp_last_of_run,
   input logic       rsp_cycle_detected
);

   // a cycle report is a single closing item with vertex zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_detected |-> rsp_last_of_run && (rsp_vertex == 5'd0))
      else $error("cycle item not closing or vertex not zero");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_SORT) |=> busy)
      else $error("sort item did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation != OP_SORT) |=> !busy)
      else $error("edge or clear item raised busy");

   // nothing follows the closing item until a new sort has run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |=> !rsp_valid)
      else $error("item after closing item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("item without a sort in progress");

endmodule

bind topological_sort_kahn tsk_checker u_tsk_checker (.*);

// ===== test/topological_sort_kahn_test.sv =====
`timescale 1ns / 1ps
module topological_sort_kahn_test;
   import tsk_pkg::*;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int VERTEX_CAP = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [4:0] vertex;
      logic       last_of_run;
      logic       cycle_detected;
   } order_entry_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_operation = OP_ADD_EDGE;
   logic [4:0] req_src_vertex = '0;
   logic [4:0] req_dst_vertex = '0;
   logic       rsp_valid;
   logic [4:0] rsp_vertex;
   logic       rsp_last_of_run;
   logic       rsp_cycle_detected;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_data = '0;

   logic [31:0]     graph_rows [VERTEX_CAP];
   logic [5:0]      vertex_count_reg = 6'd32;
   order_entry_type order_expected [$];
   int              mismatches = 0;
   int              idle_cycles = 0;
   int              send_gap_pct = 0;
   int              items_counted = 0;

   topological_sort_kahn uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_src_vertex     (req_src_vertex),
      .req_dst_vertex     (req_dst_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_vertex         (rsp_vertex),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_cycle_detected (rsp_cycle_detected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int active_count();
      int n;
      n = vertex_count_reg;
      if (n < 1) n = 1;
      if (n > VERTEX_CAP) n = VERTEX_CAP;
      return n;
   endfunction

   function automatic void predict_sort();
      int n;
      int cur;
      int indeg [VERTEX_CAP];
      int ready_list [$];
      int visit_order [$];
      n = active_count();
      foreach (indeg[j]) indeg[j] = 0;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (graph_rows[i][j]) indeg[j]++;
      for (int j = 0; j < n; j++)
         if (indeg[j] == 0) ready_list.push_back(j);
      while (ready_list.size() > 0 && visit_order.size() < n) begin
         cur = ready_list.pop_front();
         visit_order.push_back(cur);
         for (int j = 0; j < n; j++) begin
            if (graph_rows[cur][j] && indeg[j] > 0) begin
               indeg[j]--;
               if (indeg[j] == 0) ready_list.push_back(j);
            end
         end
      end
      if (visit_order.size() != n) begin
         order_expected.push_back(order_entry_type'{vertex: 5'd0, last_of_run: 1'b1,
                                                    cycle_detected: 1'b1});
      end else begin
         for (int i = 0; i < n; i++)
            order_expected.push_back(order_entry_type'{vertex: 5'(visit_order[i]),
                                                       last_of_run: (i == n - 1),
                                                       cycle_detected: 1'b0});
      end
   endfunction

   function automatic void apply_item(logic [1:0] op, logic [4:0] src, logic [4:0] dst);
      int n;
      n = active_count();
      items_counted++;
      case (op)
         OP_ADD_EDGE: begin
            if (src < n && dst < n) begin
               graph_rows[src][dst] = 1'b1;
            end
         end
         OP_SORT: begin
            predict_sort();
         end
         OP_CLEAR: begin
            foreach (graph_rows[i]) graph_rows[i] = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(string what, order_entry_type want,
                                         order_entry_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s at %0t: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                  what, $realtime, want.vertex, want.last_of_run, want.cycle_detected,
                  got.vertex, got.last_of_run, got.cycle_detected);
   endfunction

   always @(posedge clock) begin
      order_entry_type got;
      order_entry_type want;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_vertex, rsp_last_of_run, rsp_cycle_detected};
            if (order_expected.size() == 0) begin
               note_mismatch("unexpected result", '0, got);
            end else begin
               want = order_expected.pop_front();
               if (got.vertex !== want.vertex || got.last_of_run !== want.last_of_run ||
                   got.cycle_detected !== want.cycle_detected)
                  note_mismatch("result mismatch", want, got);
            end
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [4:0] src,
                            input logic [4:0] dst);
      while ($urandom_range(99) < send_gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_src_vertex = src;
      req_dst_vertex = dst;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_item(op, src, dst);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (order_expected.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_vertex_count(input logic [5:0] value);
      drain_results();
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      vertex_count_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_default_count();
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_ADD_EDGE, 5'd31, 5'd0);
      send_item(OP_SORT, 5'd31, 5'd31);
      send_item(OP_ADD_EDGE, 5'd0, 5'd31);
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_CLEAR, 5'd31, 5'd31);
      send_item(OP_SORT, 5'd0, 5'd0);
   endtask

   task automatic test_count_extremes();
      // zero count behaves as one vertex
      write_vertex_count(6'd0);
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_ADD_EDGE, 5'd1, 5'd0);
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_ADD_EDGE, 5'd0, 5'd0);
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_CLEAR, 5'd0, 5'd0);
      // count above the cap behaves as 32
      write_vertex_count(6'd63);
      send_item(OP_ADD_EDGE, 5'd31, 5'd31);
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_CLEAR, 5'd0, 5'd0);
      write_vertex_count(6'd1);
      send_item(OP_SORT, 5'd0, 5'd0);
   endtask

   task automatic test_special_cases();
      write_vertex_count(6'd32);
      send_item(OP_CLEAR, 5'd0, 5'd0);
      // edges that fall outside once the count shrinks
      send_item(OP_ADD_EDGE, 5'd10, 5'd2);
      send_item(OP_ADD_EDGE, 5'd2, 5'd20);
      write_vertex_count(6'd4);
      send_item(OP_ADD_EDGE, 5'd5, 5'd1);
      send_item(OP_RESERVED, 5'd31, 5'd31);
      send_item(OP_ADD_EDGE, 5'd2, 5'd1);
      send_item(OP_ADD_EDGE, 5'd2, 5'd1);
      send_item(OP_ADD_EDGE, 5'd3, 5'd2);
      send_item(OP_SORT, 5'd0, 5'd0);
      send_item(OP_ADD_EDGE, 5'd1, 5'd3);
      send_item(OP_SORT, 5'd0, 5'd0);
   endtask

   task automatic random_graph_run();
      int n;
      int a;
      int b;
      int t;
      int pick;
      int edges;
      int perm [VERTEX_CAP];
      n = active_count();
      for (int i = 0; i < n; i++) perm[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         a = $urandom_range(i);
         t = perm[i];
         perm[i] = perm[a];
         perm[a] = t;
      end
      if ($urandom_range(9) < 8)
         send_item(OP_CLEAR, 5'($urandom_range(31)), 5'($urandom_range(31)));
      edges = $urandom_range(0, (n < 20) ? 2 * n : 40);
      repeat (edges) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_item(OP_ADD_EDGE, 5'($urandom_range(31)), 5'($urandom_range(31)));
         end else if (pick < 12) begin
            send_item(OP_RESERVED, 5'($urandom_range(31)), 5'($urandom_range(31)));
         end else if (n >= 2) begin
            a = $urandom_range(0, n - 2);
            b = $urandom_range(a + 1, n - 1);
            send_item(OP_ADD_EDGE, 5'(perm[a]), 5'(perm[b]));
         end else begin
            send_item(OP_ADD_EDGE, 5'd0, 5'd0);
         end
      end
      pick = $urandom_range(99);
      if (pick < 20 && n >= 2) begin
         a = $urandom_range(0, n - 2);
         b = $urandom_range(a + 1, n - 1);
         send_item(OP_ADD_EDGE, 5'(perm[a]), 5'(perm[b]));
         send_item(OP_ADD_EDGE, 5'(perm[b]), 5'(perm[a]));
      end else if (pick < 28) begin
         a = perm[$urandom_range(n - 1)];
         send_item(OP_ADD_EDGE, 5'(a), 5'(a));
      end
      send_item(OP_SORT, 5'($urandom_range(31)), 5'($urandom_range(31)));
      if ($urandom_range(7) == 0) drain_results();
   endtask

   task automatic test_random_graphs();
      int gap_pct [6] = '{0, 59, 0, 24, 59, 24};
      logic [5:0] counts [6];
      int goal;
      counts = '{6'($urandom_range(2, 8)), 6'd32, 6'($urandom_range(1, 32)),
                 6'($urandom_range(9, 20)), 6'd63, 6'($urandom_range(0, 63))};
      goal = items_counted;
      for (int p = 0; p < 6; p++) begin
         write_vertex_count(counts[p]);
         send_gap_pct = gap_pct[p];
         goal += 25;
         while (items_counted < goal) random_graph_run();
      end
      send_gap_pct = 0;
   endtask

   initial begin
      foreach (graph_rows[i]) graph_rows[i] = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_default_count();
      test_count_extremes();
      test_special_cases();
      test_random_graphs();
      drain_results();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && order_expected.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
